### sv/esd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esd_pkg
// Shared types, character codes and helpers for the escape sequence decoder.
// ----------------------------------------------------------------------------
package esd_pkg;

    typedef enum logic [2:0] {
        PH_NORMAL = 3'd0,
        PH_ESC    = 3'd1,
        PH_HEX    = 3'd2,
        PH_OCT    = 3'd3,
        PH_DROP   = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_END_ESC   = 3'd1,
        ERR_HEX_EMPTY = 3'd2,
        ERR_UNICODE   = 3'd3,
        ERR_BAD_ESC   = 3'd4
    } err_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] error_code;
        logic       run_last;
        logic       string_done;
    } result_t;

    typedef struct packed {
        phase_t     phase;
        logic [7:0] digit_value;
        logic [1:0] digits_seen;
    } dec_state_t;

    // output queue sizing
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_V      = 8'h76;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_U_LO   = 8'h75;
    localparam logic [7:0] CH_U_UP   = 8'h55;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_SEVEN  = 8'h37;

    localparam logic [7:0] CC_BEL = 8'h07;
    localparam logic [7:0] CC_BS  = 8'h08;
    localparam logic [7:0] CC_FF  = 8'h0C;
    localparam logic [7:0] CC_LF  = 8'h0A;
    localparam logic [7:0] CC_CR  = 8'h0D;
    localparam logic [7:0] CC_HT  = 8'h09;
    localparam logic [7:0] CC_VT  = 8'h0B;

    function automatic result_t mk_result(logic [7:0] b, err_t err, logic done);
        result_t r;
        r.out_byte    = b;
        r.error_code  = err;
        r.run_last    = 1'b0;
        r.string_done = done;
        return r;
    endfunction

    function automatic logic is_hex(logic [7:0] b);
        return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66) ||
               (b >= 8'h41 && b <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_val(logic [7:0] b);
        logic [7:0] v;
        if (b <= 8'h39) begin
            v = b - 8'h30;
        end else if (b >= 8'h61) begin
            v = b - 8'h57;
        end else begin
            v = b - 8'h37;
        end
        return v[3:0];
    endfunction

endpackage

### sv/esd_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esd_decode
// Per-byte escape decode: next state and up to two results for one item.
// ----------------------------------------------------------------------------
module esd_decode import esd_pkg::*; (
    input  dec_state_t st,
    input  logic [7:0] in_byte,
    input  logic       end_of_string,
    output dec_state_t st_next,
    output logic [1:0] res_n,
    output result_t    res0,
    output result_t    res1
);

    logic       is_bs;
    logic       p_emit;
    result_t    p_res;
    phase_t     p_phase;
    logic       oct_dig;
    logic [7:0] hex_acc;
    logic [7:0] oct_acc;
    logic [1:0] seen_inc;
    result_t    r0;
    result_t    r1;

    // behavior of a byte seen in pass-through phase
    assign is_bs   = (in_byte == CH_BSLASH);
    assign p_emit  = !(is_bs && !end_of_string);
    assign p_res   = is_bs ? mk_result(8'h00, ERR_END_ESC, 1'b1)
                           : mk_result(in_byte, ERR_NONE, end_of_string);
    assign p_phase = (is_bs && !end_of_string) ? PH_ESC : PH_NORMAL;

    assign oct_dig  = (in_byte >= CH_ZERO) && (in_byte <= CH_SEVEN);
    assign hex_acc  = {st.digit_value[3:0], hex_val(in_byte)};
    assign oct_acc  = {st.digit_value[4:0], in_byte[2:0]};
    assign seen_inc = st.digits_seen + 2'd1;

    always_comb begin
        st_next = st;
        res_n   = 2'd0;
        r0      = '0;
        r1      = '0;
        unique case (st.phase)
            PH_ESC: begin
                st_next.phase = PH_NORMAL;
                res_n         = 2'd1;
                unique case (in_byte) inside
                    CH_SQUOTE, CH_DQUOTE, CH_QMARK, CH_BSLASH:
                        r0 = mk_result(in_byte, ERR_NONE, end_of_string);
                    CH_A: r0 = mk_result(CC_BEL, ERR_NONE, end_of_string);
                    CH_B: r0 = mk_result(CC_BS, ERR_NONE, end_of_string);
                    CH_F: r0 = mk_result(CC_FF, ERR_NONE, end_of_string);
                    CH_N: r0 = mk_result(CC_LF, ERR_NONE, end_of_string);
                    CH_R: r0 = mk_result(CC_CR, ERR_NONE, end_of_string);
                    CH_T: r0 = mk_result(CC_HT, ERR_NONE, end_of_string);
                    CH_V: r0 = mk_result(CC_VT, ERR_NONE, end_of_string);
                    CH_X: begin
                        if (end_of_string) begin
                            r0 = mk_result(8'h00, ERR_HEX_EMPTY, 1'b1);
                        end else begin
                            res_n         = 2'd0;
                            st_next.phase = PH_HEX;
                        end
                        st_next.digit_value = 8'h00;
                        st_next.digits_seen = 2'd0;
                    end
                    CH_U_LO, CH_U_UP: begin
                        r0                  = mk_result(8'h00, ERR_UNICODE, 1'b1);
                        st_next.phase       = end_of_string ? PH_NORMAL : PH_DROP;
                        st_next.digit_value = 8'h00;
                        st_next.digits_seen = 2'd0;
                    end
                    [CH_ZERO:CH_SEVEN]: begin
                        if (end_of_string) begin
                            r0                  = mk_result({5'd0, in_byte[2:0]},
                                                            ERR_NONE, 1'b1);
                            st_next.digit_value = 8'h00;
                            st_next.digits_seen = 2'd0;
                        end else begin
                            res_n               = 2'd0;
                            st_next.phase       = PH_OCT;
                            st_next.digit_value = {5'd0, in_byte[2:0]};
                            st_next.digits_seen = 2'd1;
                        end
                    end
                    default: begin
                        r0                  = mk_result(8'h00, ERR_BAD_ESC, 1'b1);
                        st_next.phase       = end_of_string ? PH_NORMAL : PH_DROP;
                        st_next.digit_value = 8'h00;
                        st_next.digits_seen = 2'd0;
                    end
                endcase
            end
            PH_HEX: begin
                if (is_hex(in_byte)) begin
                    if (seen_inc >= 2'd2 || end_of_string) begin
                        res_n               = 2'd1;
                        r0                  = mk_result(hex_acc, ERR_NONE, end_of_string);
                        st_next.phase       = PH_NORMAL;
                        st_next.digit_value = 8'h00;
                        st_next.digits_seen = 2'd0;
                    end else begin
                        st_next.digit_value = hex_acc;
                        st_next.digits_seen = seen_inc;
                    end
                end else if (st.digits_seen == 2'd0) begin
                    // no digits: the terminator goes with the error
                    res_n               = 2'd1;
                    r0                  = mk_result(8'h00, ERR_HEX_EMPTY, 1'b1);
                    st_next.phase       = end_of_string ? PH_NORMAL : PH_DROP;
                    st_next.digit_value = 8'h00;
                    st_next.digits_seen = 2'd0;
                end else begin
                    res_n               = p_emit ? 2'd2 : 2'd1;
                    r0                  = mk_result(st.digit_value, ERR_NONE, 1'b0);
                    r1                  = p_res;
                    st_next.phase       = p_phase;
                    st_next.digit_value = 8'h00;
                    st_next.digits_seen = 2'd0;
                end
            end
            PH_OCT: begin
                if (oct_dig) begin
                    if (seen_inc >= 2'd3 || end_of_string) begin
                        res_n               = 2'd1;
                        r0                  = mk_result(oct_acc, ERR_NONE, end_of_string);
                        st_next.phase       = PH_NORMAL;
                        st_next.digit_value = 8'h00;
                        st_next.digits_seen = 2'd0;
                    end else begin
                        st_next.digit_value = oct_acc;
                        st_next.digits_seen = seen_inc;
                    end
                end else begin
                    res_n               = p_emit ? 2'd2 : 2'd1;
                    r0                  = mk_result(st.digit_value, ERR_NONE, 1'b0);
                    r1                  = p_res;
                    st_next.phase       = p_phase;
                    st_next.digit_value = 8'h00;
                    st_next.digits_seen = 2'd0;
                end
            end
            PH_DROP: begin
                if (end_of_string) begin
                    st_next.phase = PH_NORMAL;
                end
            end
            default: begin
                res_n         = p_emit ? 2'd1 : 2'd0;
                r0            = p_res;
                st_next.phase = p_phase;
                if (p_emit && is_bs) begin
                    st_next.digit_value = 8'h00;
                    st_next.digits_seen = 2'd0;
                end
            end
        endcase
    end

    // mark the last result of this item
    always_comb begin
        res0          = r0;
        res1          = r1;
        res0.run_last = (res_n == 2'd1);
        res1.run_last = (res_n == 2'd2);
    end

endmodule

### sv/esd_outq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esd_outq
// Small result queue: takes up to two results a cycle, hands out one.
// ----------------------------------------------------------------------------
module esd_outq import esd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [1:0] push_n,
    input  result_t    push0,
    input  result_t    push1,
    output logic       room,
    output logic       out_valid,
    input  logic       out_ready,
    output result_t    out_res
);

    result_t             q_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                pop;

    // room for a worst-case item of two results
    assign room      = (count_reg <= QCNT_W'(QDEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign out_res   = q_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    assign wr_ptr_next = wr_ptr_reg + QPTR_W'(push_n);
    assign rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
    assign count_next  = count_reg + QCNT_W'(push_n) - QCNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            q_reg[wr_ptr_reg] <= push0;
        end
        if (push_n == 2'd2) begin
            q_reg[wr_ptr_reg + QPTR_W'(1)] <= push1;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("result queue overflow");

    a_push_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_n == 2'd2) |-> (count_reg <= QCNT_W'(QDEPTH - 2)))
        else $error("double push without room");

    a_pop_moves_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && push_n == 2'd0) |=> (count_reg == $past(count_reg) - QCNT_W'(1)))
        else $error("pop did not drain queue");

endmodule

### sv/escape_sequence_decoder_unit.sv
`timescale 1ns / 1ps
// results are written into the registered result queue when their input item is accepted, and leave it on m_
// throughput: one input byte per cycle while s_ready is high; an item gives zero, one or two results
// items that give two results are handed out one result at a time, so the 4-entry result
// queue can push back on s_ready when such items arrive in a row
// reset: synchronous active-low aresetn clears the decode state and empties the queue
// ----------------------------------------------------------------------------
// escape_sequence_decoder_unit
// C-style backslash escape decoder with a small result queue on the output.
// ----------------------------------------------------------------------------
module escape_sequence_decoder_unit import esd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_end_of_string,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic [2:0] m_error_code,
    output logic       m_run_last,
    output logic       m_string_done
);

    dec_state_t st_reg;
    dec_state_t st_next;
    logic [1:0] res_n;
    logic [1:0] push_n;
    result_t    res0;
    result_t    res1;
    result_t    out_res;
    logic       room;
    logic       accept;

    assign s_ready = room;
    assign accept  = s_valid && room;
    assign push_n  = accept ? res_n : 2'd0;

    esd_decode u_decode (
        .st            (st_reg),
        .in_byte       (s_in_byte),
        .end_of_string (s_end_of_string),
        .st_next       (st_next),
        .res_n         (res_n),
        .res0          (res0),
        .res1          (res1)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.phase       <= PH_NORMAL;
            st_reg.digit_value <= 8'h00;
            st_reg.digits_seen <= 2'd0;
        end else if (accept) begin
            st_reg <= st_next;
        end
    end

    esd_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_n    (push_n),
        .push0     (res0),
        .push1     (res1),
        .room      (room),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_res   (out_res)
    );

    assign m_out_byte    = out_res.out_byte;
    assign m_error_code  = out_res.error_code;
    assign m_run_last    = out_res.run_last;
    assign m_string_done = out_res.string_done;

    a_end_returns_normal: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_end_of_string) |=> (st_reg.phase == PH_NORMAL))
        else $error("string end did not return to pass-through");

    a_digits_only_numeric: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg.phase != PH_HEX && st_reg.phase != PH_OCT) |-> (st_reg.digits_seen == 2'd0))
        else $error("digit count left over outside numeric escape");

    a_drop_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && st_reg.phase == PH_DROP && !s_end_of_string)
            |-> (res_n == 2'd0) ##1 (st_reg.phase == PH_DROP))
        else $error("dropped string produced output or left drop phase");

    a_error_result_form: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_error_code != ERR_NONE) |-> (m_out_byte == 8'h00 && m_string_done))
        else $error("error item not zero or not marked done");

endmodule
